// File: hw/rtl/frtc_pkg.sv
// Shared types and constants of the firewall region table checker.
// Used by the region cell, the top level and the port checker.
package frtc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int INST_CNT = 2;

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W = 5;
   localparam int CMP_W = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

   localparam int ADDR_W = 64;
   localparam int PROT_W = 32;
   localparam int REQ_W = 168;
   localparam int RSP_W = 8;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NO_INSTANCE    = 3'd1,
      ST_WRONG_INSTANCE = 3'd2,
      ST_INSTANCE_FULL  = 3'd3,
      ST_TABLE_FULL     = 3'd4,
      ST_OVERLAP        = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_BASE_A  = 3'd0,
      REG_SIZE_A  = 3'd1,
      REG_BASE_B  = 3'd2,
      REG_SIZE_B  = 3'd3,
      REG_GRAIN_A = 3'd4,
      REG_GRAIN_B = 3'd5,
      REG_LIMIT_A = 3'd6,
      REG_LIMIT_B = 3'd7
   } reg_index_type;

   localparam logic [1:0] WANT_ANY = 2'b11;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] stop;
      logic              inst;
   } query_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] stop;
      logic              inst;
      logic [PROT_W-1:0] prot;
   } write_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } token_type;

endpackage

// File: hw/rtl/frtc_cell.sv
// One table slot of the region chain: holds a stored region and checks the
// passing scan token against it. Depends on frtc_pkg.
module frtc_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [frtc_pkg::SLOT_W-1:0] cell_idx,
   input  logic [frtc_pkg::CNT_W-1:0]  used,
   input  frtc_pkg::query_type         query,
   input  frtc_pkg::write_type         wr,
   input  frtc_pkg::token_type         tok_in,
   output frtc_pkg::token_type         tok_out
);
   import frtc_pkg::*;

   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] stop_ff;
   logic              inst_ff;
   logic [PROT_W-1:0] prot_ff;
   token_type         tok_ff;
   token_type         tok_in_next;
   logic              occupied;
   logic              hit_here;

   assign occupied = CNT_W'(cell_idx) < used;
   assign hit_here = occupied && (inst_ff == query.inst) &&
                     !((query.start >= stop_ff) || (start_ff >= query.stop));

   always_comb begin
      tok_in_next.valid = tok_in.valid;
      tok_in_next.hit   = tok_in.hit | (tok_in.valid & hit_here);
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == cell_idx)) begin
         start_ff <= wr.start;
         stop_ff  <= wr.stop;
         inst_ff  <= wr.inst;
         prot_ff  <= wr.prot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: hw/rtl/firewall_region_table_checker.sv
// Firewall region table checker: each request item returns one status item
// and, when every check passes, registers one protection region. A request
// rejected before the overlap check passes through S_ADD, S_CMP and S_DONE;
// one that reaches it also waits in S_SCAN until the scan token, walking
// the chain of table cells one cell per cycle, leaves the last cell. One item
// is worked at a time; a finished status waits in the output register while
// the next item is taken. Depends on frtc_pkg and frtc_cell.
module firewall_region_table_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // region_start[63:0], region_length[127:64], wanted_instance[129:128],
   // protection_word[161:130], zero pad[167:162]
   input  logic [frtc_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[2:0], found_instance[3], slot_index[7:4]
   output logic [frtc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [63:0]                 csr_wdata
);
   import frtc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_ADD, S_CMP, S_SCAN, S_DONE} state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  base_ff  [2];
   logic [ADDR_W-1:0]  size_ff  [2];
   logic [4:0]         grain_ff [2];
   logic [LIM_W-1:0]   limit_ff [2];

   logic [ADDR_W-1:0]  q_start_ff;
   logic [ADDR_W-1:0]  q_len_ff;
   logic [1:0]         q_wanted_ff;
   logic [PROT_W-1:0]  q_prot_ff;
   logic [ADDR_W-1:0]  q_last_ff;
   logic [ADDR_W-1:0]  q_stop_ff;
   logic [ADDR_W-1:0]  last_ff  [2];
   logic [1:0]         lo_ok_ff;
   logic               found_ff;
   status_type         status_ff;
   logic               launch_ff;

   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   inst_used_ff [2];

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_found_ff;
   logic [3:0]         rsp_slot_ff;

   logic [ADDR_W-1:0]  last_in  [2];
   logic [1:0]         lo_ok_in;
   logic [1:0]         fit_now;
   logic               found_now;
   logic               wrong_now;
   logic               full_now;
   logic               pass_now;
   logic               done_fire;
   query_type          query;
   write_type          wr;
   token_type          tok [TABLE_DEPTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            base_ff[i]  <= '0;
            size_ff[i]  <= '0;
            grain_ff[i] <= '0;
            limit_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_BASE_A:  base_ff[0]  <= csr_wdata;
            REG_SIZE_A:  size_ff[0]  <= csr_wdata;
            REG_BASE_B:  base_ff[1]  <= csr_wdata;
            REG_SIZE_B:  size_ff[1]  <= csr_wdata;
            REG_GRAIN_A: grain_ff[0] <= csr_wdata[4:0];
            REG_GRAIN_B: grain_ff[1] <= csr_wdata[4:0];
            REG_LIMIT_A: limit_ff[0] <= csr_wdata[LIM_W-1:0];
            REG_LIMIT_B: limit_ff[1] <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         logic [ADDR_W-1:0] mask;
         mask = (64'd1 << grain_ff[i]) - 64'd1;
         last_in[i]  = base_ff[i] + size_ff[i] - 64'd1;
         lo_ok_in[i] = (size_ff[i] != '0) && (q_start_ff >= base_ff[i]) &&
                       (q_len_ff != '0) && ((q_start_ff & mask) == '0) &&
                       ((q_len_ff & mask) == '0);
         fit_now[i]  = (i < INST_CNT) && lo_ok_ff[i] &&
                       (q_start_ff <= last_ff[i]) && (q_last_ff <= last_ff[i]);
      end
   end

   assign found_now = fit_now[1];
   assign wrong_now = (q_wanted_ff != WANT_ANY) && (q_wanted_ff != {1'b0, found_now});
   assign full_now  = (CMP_W'(inst_used_ff[found_now]) + CMP_W'(1)) >
                      CMP_W'(limit_ff[found_now]);
   assign pass_now  = (fit_now != 2'b00) && !wrong_now && !full_now &&
                      (used_ff != CNT_W'(TABLE_DEPTH));
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign query.start = q_start_ff;
   assign query.stop  = q_stop_ff;
   assign query.inst  = found_ff;

   assign wr.en    = done_fire && (status_ff == ST_OK);
   assign wr.slot  = used_ff[SLOT_W-1:0];
   assign wr.start = q_start_ff;
   assign wr.stop  = q_stop_ff;
   assign wr.inst  = found_ff;
   assign wr.prot  = q_prot_ff;

   assign tok[0].valid = launch_ff;
   assign tok[0].hit   = 1'b0;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      frtc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(k)),
         .used     (used_ff),
         .query    (query),
         .wr       (wr),
         .tok_in   (tok[k]),
         .tok_out  (tok[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         launch_ff     <= 1'b0;
         used_ff       <= '0;
         inst_used_ff[0] <= '0;
         inst_used_ff[1] <= '0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= ST_OK;
         found_ff      <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_found_ff  <= 1'b0;
         rsp_slot_ff   <= '0;
      end else begin
         launch_ff    <= (state_ff == S_CMP) && pass_now;
         rsp_valid_ff <= done_fire || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  q_start_ff  <= req_tdata[63:0];
                  q_len_ff    <= req_tdata[127:64];
                  q_wanted_ff <= req_tdata[129:128];
                  q_prot_ff   <= req_tdata[161:130];
                  state_ff    <= S_ADD;
               end
            end
            S_ADD: begin
               last_ff[0] <= last_in[0];
               last_ff[1] <= last_in[1];
               lo_ok_ff   <= lo_ok_in;
               q_last_ff  <= q_start_ff - 64'd1 + q_len_ff;
               q_stop_ff  <= q_start_ff + q_len_ff;
               state_ff   <= S_CMP;
            end
            S_CMP: begin
               found_ff <= found_now;
               state_ff <= pass_now ? S_SCAN : S_DONE;
               if (fit_now == 2'b00) begin
                  status_ff <= ST_NO_INSTANCE;
               end else if (wrong_now) begin
                  status_ff <= ST_WRONG_INSTANCE;
               end else if (full_now) begin
                  status_ff <= ST_INSTANCE_FULL;
               end else if (used_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_ff <= ST_TABLE_FULL;
               end else begin
                  status_ff <= ST_OK;
               end
            end
            S_SCAN: begin
               if (tok[TABLE_DEPTH].valid) begin
                  status_ff <= tok[TABLE_DEPTH].hit ? ST_OVERLAP : ST_OK;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (done_fire) begin
                  rsp_status_ff <= status_ff;
                  rsp_found_ff  <= found_ff;
                  rsp_slot_ff   <= (status_ff == ST_OK) ? 4'(used_ff) : 4'd0;
                  if (status_ff == ST_OK) begin
                     used_ff                <= used_ff + CNT_W'(1);
                     inst_used_ff[found_ff] <= inst_used_ff[found_ff] + CNT_W'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_slot_ff, rsp_found_ff, rsp_status_ff};

endmodule

// File: hw/rtl/frtc_checker.sv
// Port-level checks of the firewall region table checker, bound to the top
// level. Depends on frtc_pkg.
module frtc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [frtc_pkg::REQ_W-1:0] req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [frtc_pkg::RSP_W-1:0] rsp_tdata,
   input logic                       csr_we,
   input logic [2:0]                 csr_index,
   input logic [63:0]                csr_wdata
);
   import frtc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_OVERLAP)
      else $error("status code out of range");

   a_no_inst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_NO_INSTANCE |-> rsp_tdata[7:3] == 5'd0)
      else $error("no-instance result carries instance or slot");

   a_reject_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[7:4] == 4'd0)
      else $error("rejected item carries a slot");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

endmodule

bind firewall_region_table_checker frtc_checker u_frtc_checker (.*);

// File: bench/region_verdict_checker.sv
// Stream checker for the firewall region table checker: mirrors the window
// registers and the region table, predicts one status item per request item
// and compares it with the returned item. Depends on frtc_pkg.
module region_verdict_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [frtc_pkg::REQ_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [frtc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [63:0]                csr_wdata,
   output int                         mismatches,
   output int                         awaited,
   output int                         verdicts_checked,
   output logic [5:0]                 status_seen
);
   import frtc_pkg::*;

   typedef struct packed {
      status_type        status;
      logic              inst;
      logic [SLOT_W-1:0] slot;
   } verdict_type;

   logic [63:0] fw_base [INST_CNT];
   logic [63:0] fw_size [INST_CNT];
   logic [4:0]  fw_grain [INST_CNT];
   logic [4:0]  fw_cap [INST_CNT];

   logic [63:0] tbl_start [TABLE_DEPTH];
   logic [63:0] tbl_len [TABLE_DEPTH];
   logic        tbl_inst [TABLE_DEPTH];
   int          tbl_fill;
   int          inst_fill [INST_CNT];

   verdict_type awaited_verdicts [$];

   function automatic bit window_holds(int i, logic [63:0] start, logic [63:0] len);
      logic [63:0] last;
      logic [63:0] mask;
      logic [63:0] stop;
      if (start < fw_base[i] || len == 64'd0)
         return 1'b0;
      last = fw_base[i] + fw_size[i] - 64'd1;
      stop = start - 64'd1 + len;
      if (start > last || stop > last)
         return 1'b0;
      mask = (64'd1 << fw_grain[i]) - 64'd1;
      return ((start & mask) == 64'd0) && ((len & mask) == 64'd0);
   endfunction

   function automatic bit ranges_meet(logic [63:0] a1, logic [63:0] l1,
                                      logic [63:0] a2, logic [63:0] l2);
      logic [63:0] end1;
      logic [63:0] end2;
      end1 = a1 + l1;
      end2 = a2 + l2;
      return !((a1 >= end2) || (a2 >= end1));
   endfunction

   task automatic predict_registration(input logic [63:0] start, input logic [63:0] len,
                                       input logic [1:0] want, output verdict_type v);
      bit   have;
      bit   clash;
      logic holder;
      have = 1'b0;
      clash = 1'b0;
      holder = 1'b0;
      for (int i = 0; i < INST_CNT; i++) begin
         if (fw_size[i] != 64'd0 && window_holds(i, start, len)) begin
            have = 1'b1;
            holder = i[0];
         end
      end
      v.status = ST_OK;
      v.inst = holder;
      v.slot = '0;
      if (!have) begin
         v.status = ST_NO_INSTANCE;
      end else if (want != WANT_ANY && want != {1'b0, holder}) begin
         v.status = ST_WRONG_INSTANCE;
      end else if (inst_fill[holder] + 1 > fw_cap[holder]) begin
         v.status = ST_INSTANCE_FULL;
      end else if (tbl_fill >= TABLE_DEPTH) begin
         v.status = ST_TABLE_FULL;
      end else begin
         for (int k = 0; k < tbl_fill; k++) begin
            if (tbl_inst[k] == holder && ranges_meet(start, len, tbl_start[k], tbl_len[k]))
               clash = 1'b1;
         end
         if (clash) begin
            v.status = ST_OVERLAP;
         end else begin
            tbl_start[tbl_fill] = start;
            tbl_len[tbl_fill] = len;
            tbl_inst[tbl_fill] = holder;
            v.slot = tbl_fill[SLOT_W-1:0];
            tbl_fill++;
            inst_fill[holder]++;
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [3:0] exp_v,
                                input logic [3:0] got_v);
      if (got_v !== exp_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      verdict_type v;
      if (reset) begin
         for (int i = 0; i < INST_CNT; i++) begin
            fw_base[i] = '0;
            fw_size[i] = '0;
            fw_grain[i] = '0;
            fw_cap[i] = '0;
            inst_fill[i] = 0;
         end
         tbl_fill = 0;
         mismatches = 0;
         verdicts_checked = 0;
         status_seen <= '0;
         awaited_verdicts.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_BASE_A:  fw_base[0] = csr_wdata;
               REG_SIZE_A:  fw_size[0] = csr_wdata;
               REG_BASE_B:  fw_base[1] = csr_wdata;
               REG_SIZE_B:  fw_size[1] = csr_wdata;
               REG_GRAIN_A: fw_grain[0] = csr_wdata[4:0];
               REG_GRAIN_B: fw_grain[1] = csr_wdata[4:0];
               REG_LIMIT_A: fw_cap[0] = csr_wdata[4:0];
               REG_LIMIT_B: fw_cap[1] = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               v = awaited_verdicts.pop_front();
               compare_field("status", {1'b0, v.status}, {1'b0, rsp_tdata[2:0]});
               compare_field("found_instance", {3'b0, v.inst}, {3'b0, rsp_tdata[3]});
               compare_field("slot_index", v.slot, rsp_tdata[7:4]);
               status_seen[v.status] <= 1'b1;
               verdicts_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_registration(req_tdata[63:0], req_tdata[127:64], req_tdata[129:128], v);
            awaited_verdicts.push_back(v);
         end
      end
      awaited = awaited_verdicts.size();
   end

endmodule

// File: bench/testbench.sv
// Top of the region table checker bench: clock, reset, window setups and
// region request items, random idling on both channels and the verdict.
// Depends on frtc_pkg, firewall_region_table_checker and region_verdict_checker.
module testbench;
   import frtc_pkg::*;

   localparam logic [1:0] WANT_INST0 = 2'b00;
   localparam logic [1:0] WANT_INST1 = 2'b01;
   localparam logic [1:0] WANT_NONE  = 2'b10;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 30;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [2:0]       csr_index;
   logic [63:0]      csr_wdata;

   int         mismatches;
   int         awaited;
   int         verdicts_checked;
   logic [5:0] status_seen;

   bit          steady = 1'b0;
   bit          hold_ask = 1'b0;
   int          items_sent = 0;
   int          quiet_cycles = 0;
   logic [63:0] cfg_base [2];
   logic [63:0] cfg_size [2];
   int          cfg_grain [2];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   firewall_region_table_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   region_verdict_checker region_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .awaited          (awaited),
      .verdicts_checked (verdicts_checked),
      .status_seen      (status_seen)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 29);
         end
      end
   end

   task automatic write_csr(input reg_index_type idx, input logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [63:0] base_a, input logic [63:0] size_a,
                             input logic [63:0] base_b, input logic [63:0] size_b,
                             input int grain_a, input int grain_b,
                             input int limit_a, input int limit_b);
      write_csr(REG_BASE_A, base_a);
      write_csr(REG_SIZE_A, size_a);
      write_csr(REG_BASE_B, base_b);
      write_csr(REG_SIZE_B, size_b);
      write_csr(REG_GRAIN_A, 64'(grain_a));
      write_csr(REG_GRAIN_B, 64'(grain_b));
      write_csr(REG_LIMIT_A, 64'(limit_a));
      write_csr(REG_LIMIT_B, 64'(limit_b));
      csr_we <= 1'b0;
      cfg_base[0] = base_a;
      cfg_size[0] = size_a;
      cfg_base[1] = base_b;
      cfg_size[1] = size_b;
      cfg_grain[0] = grain_a;
      cfg_grain[1] = grain_b;
   endtask

   task automatic send_region(input logic [63:0] start, input logic [63:0] len,
                              input logic [1:0] want, input logic [31:0] prot);
      while (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {6'b0, prot, want, len, start};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (awaited != 0) @(negedge clock);
   endtask

   // mostly regions shaped to a present window, some broken ones, some noise
   task automatic random_region();
      logic [63:0] start;
      logic [63:0] len;
      logic [63:0] units;
      logic [63:0] k;
      logic [63:0] room;
      logic [1:0]  want;
      int          pick;
      int          i;
      int          g;
      pick = $urandom_range(99);
      start = {$urandom, $urandom};
      len = {$urandom, $urandom};
      want = 2'($urandom_range(3));
      if (cfg_size[1] == 64'd0)
         i = 0;
      else if (cfg_size[0] == 64'd0)
         i = 1;
      else
         i = $urandom_range(1);
      g = cfg_grain[i];
      units = cfg_size[i] >> g;
      if (pick < 85 && units != 64'd0) begin
         k = {$urandom, $urandom} % units;
         room = units - k;
         if (room > 64'd4)
            room = 64'd4;
         start = cfg_base[i] + (k << g);
         len = (64'd1 + {$urandom, $urandom} % room) << g;
         case ($urandom_range(4))
            0, 1: want = WANT_ANY;
            2: want = {1'b0, i[0]};
            default: ;
         endcase
         if (pick >= 70) begin
            case ($urandom_range(3))
               0: len = 64'd0;
               1: start = start + 64'd1;
               2: len = len + cfg_size[i];
               default: start = cfg_base[i] - (64'd1 << g);
            endcase
         end
      end
      send_region(start, len, want, $urandom);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = REG_BASE_A;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // overlapping windows, small limits
      set_config(64'h1000_0000, 64'h1000_0000, 64'h1800_0000, 64'h0800_0000, 12, 16, 3, 2);
      send_region(64'h1000_0000, 64'h0, WANT_ANY, 32'h1234_5678);
      send_region(64'h0FFF_F000, 64'h1000, WANT_ANY, 32'h0);
      send_region(64'h1000_0800, 64'h1000, WANT_ANY, 32'h0);
      send_region(64'h1000_0000, 64'h2000, WANT_ANY, 32'h0);
      send_region(64'h1000_1000, 64'h1000, WANT_INST0, 32'hFFFF_FFFF);
      send_region(64'h1000_2000, 64'h1000, WANT_INST0, 32'hA5A5_5A5A);
      send_region(64'h1800_0000, 64'h1_0000, WANT_INST1, 32'h5A5A_A5A5);
      send_region(64'h1800_0000, 64'h1_0000, WANT_ANY, 32'h0);
      send_region(64'h1801_0000, 64'h1_0000, WANT_INST0, 32'h0);
      send_region(64'h1802_0000, 64'h1_0000, WANT_NONE, 32'h0);
      send_region(64'h1800_1000, 64'h1000, WANT_ANY, 32'h0);
      send_region(64'h1000_4000, 64'h1000, WANT_ANY, 32'h0);
      send_region(64'h1803_0000, 64'h1_0000, WANT_ANY, 32'h0);
      send_region(64'h1804_0000, 64'h1_0000, WANT_ANY, 32'h0);
      send_region(64'h1FFF_F000, 64'h2000, WANT_ANY, 32'h0);
      send_region(64'h2000_0000, 64'h1000, WANT_ANY, 32'h0);
      send_region(64'hFFFF_FFFF_FFFF_F000, 64'h2000, WANT_ANY, 32'h0);
      send_region(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, WANT_INST1, 32'hFFFF_FFFF);
      drain();

      // tight nested windows: overlaps dominate
      steady = 1'b1;
      set_config(64'h40_0000_0000, 64'h600, 64'h40_0000_0200, 64'h400, 8, 8, 16, 16);
      for (int n = 0; n < 250; n++) begin
         if (n == 80)
            steady = 1'b0;
         if (n == 120)
            hold_ask = 1'b1;
         random_region();
      end
      drain();

      // zero limit on one side, window ending at the top of the address space
      set_config(64'h0, 64'h1_0000, 64'hFFFF_FFFF_FFFF_FF00, 64'h100, 0, 2, 0, 16);
      repeat (150) random_region();
      drain();

      // full-range windows: fill the table
      set_config(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h8000_0000_0000_0000, 31, 20, 16, 16);
      repeat (150) random_region();
      drain();

      // wrapped window and an absent instance
      set_config(64'hFFFF_FFFF_FFFF_FFC0, 64'h80, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, 31, 0, 16);
      repeat (100) random_region();
      drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Sent %0d region requests over five window setups; %0d statuses compared.",
               items_sent, verdicts_checked);
      $display("Status codes returned, one bit per code with ok lowest: %b", status_seen);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/frtc_pkg.sv
hw/rtl/frtc_cell.sv
hw/rtl/firewall_region_table_checker.sv
hw/rtl/frtc_checker.sv
bench/region_verdict_checker.sv
bench/testbench.sv
